// ===== design/qbs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbs_pkg
// Shared sizes, codes and types of the quadratic b-spline point evaluator.
// ----------------------------------------------------------------------------
package qbs_pkg;

  localparam int MAX_POINTS = 64;
  localparam int COORD_W    = 16;
  localparam int FRAC_W     = 16;
  localparam int IDX_W      = $clog2(MAX_POINTS);
  localparam int CNT_W      = 7;

  // weights are exact at scale 2^(2*FRAC_W+1); the largest is 2^(2*FRAC_W+1)
  localparam int WEIGHT_W   = 2 * FRAC_W + 2;
  localparam int PROD_W     = WEIGHT_W + 1 + COORD_W;
  localparam int ACC_W      = PROD_W + 1;
  localparam int TOT_SHIFT  = 2 * FRAC_W + 1;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_EVAL  = 1'b1;

  typedef enum logic [1:0] {
    MODE_LINEAR,
    MODE_FIRST,
    MODE_LAST,
    MODE_UNIFORM
  } mode_t;

  typedef enum logic [1:0] {
    TAP_0,
    TAP_1,
    TAP_2
  } tap_t;

  typedef logic [WEIGHT_W-1:0] weight_t;

  // travels with each table read, aligned with the read data
  typedef struct packed {
    logic valid;
    tap_t sel;
    logic first;
    logic last;
    logic use_pt;
  } rd_ctl_t;

endpackage

// ===== design/qbs_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbs_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module qbs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/qbs_weights.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbs_weights
// Blend weights from the fraction: squares in one stage, weights in the next.
// ----------------------------------------------------------------------------
module qbs_weights (
  input  logic                          clk,
  input  logic [qbs_pkg::FRAC_W-1:0]    frac,
  input  qbs_pkg::mode_t                mode,
  output qbs_pkg::weight_t              w0,
  output qbs_pkg::weight_t              w1,
  output qbs_pkg::weight_t              w2
);
  import qbs_pkg::*;

  localparam int EXT_W = WEIGHT_W + 1;
  localparam logic [FRAC_W:0] ONE_U = {1'b1, {FRAC_W{1'b0}}};

  logic [FRAC_W:0]     u;
  logic [FRAC_W-1:0]   f_q;
  logic [FRAC_W:0]     u_q;
  logic [2*FRAC_W-1:0] ff;
  logic [2*FRAC_W+1:0] uu;
  mode_t               mode_q;

  logic [EXT_W-1:0] f_e, u_e, ff_e, uu_e, oo_e;
  logic [EXT_W-1:0] w0_next, w1_next, w2_next;

  assign u = ONE_U - {1'b0, frac};

  always_ff @(posedge clk) begin
    f_q    <= frac;
    u_q    <= u;
    ff     <= frac * frac;
    uu     <= u * u;
    mode_q <= mode;
  end

  always_comb begin
    f_e  = EXT_W'(f_q);
    u_e  = EXT_W'(u_q);
    ff_e = EXT_W'(ff);
    uu_e = EXT_W'(uu);
    oo_e = EXT_W'(1) << (2 * FRAC_W);
    unique case (mode_q)
      MODE_LINEAR: begin
        // linear blend lifted to the spline scale
        w0_next = f_e << (FRAC_W + 1);
        w1_next = u_e << (FRAC_W + 1);
        w2_next = '0;
      end
      MODE_FIRST: begin
        w0_next = uu_e << 1;
        w1_next = (f_e << (FRAC_W + 2)) - ((ff_e << 1) + ff_e);
        w2_next = ff_e;
      end
      MODE_LAST: begin
        w0_next = uu_e;
        w1_next = oo_e + (f_e << (FRAC_W + 1)) - ((ff_e << 1) + ff_e);
        w2_next = ff_e << 1;
      end
      default: begin
        w0_next = uu_e;
        w1_next = oo_e + (f_e << (FRAC_W + 1)) - (ff_e << 1);
        w2_next = ff_e;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    w0 <= w0_next[WEIGHT_W-1:0];
    w1 <= w1_next[WEIGHT_W-1:0];
    w2 <= w2_next[WEIGHT_W-1:0];
  end

endmodule

// ===== design/qbs_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qbs_mac
// One axis: weight times coordinate per read beat, accumulate, round, saturate.
// ----------------------------------------------------------------------------
module qbs_mac (
  input  logic                                clk,
  input  logic                                rst,
  input  qbs_pkg::rd_ctl_t                    ctl,
  input  qbs_pkg::weight_t                    w0,
  input  qbs_pkg::weight_t                    w1,
  input  qbs_pkg::weight_t                    w2,
  input  logic signed [qbs_pkg::COORD_W-1:0]  coord,
  output logic                                res_valid,
  output logic signed [qbs_pkg::COORD_W-1:0]  res
);
  import qbs_pkg::*;

  localparam int RND_W = ACC_W - TOT_SHIFT;
  localparam logic signed [ACC_W-1:0] HALF =
    {{(ACC_W - TOT_SHIFT){1'b0}}, 1'b1, {(TOT_SHIFT - 1){1'b0}}};
  localparam logic signed [RND_W-1:0] MAX_R =
    {{(RND_W - COORD_W + 1){1'b0}}, {(COORD_W - 1){1'b1}}};
  localparam logic signed [RND_W-1:0] MIN_R =
    {{(RND_W - COORD_W + 1){1'b1}}, {(COORD_W - 1){1'b0}}};

  weight_t                    w_sel;
  logic signed [COORD_W-1:0]  c_use;
  logic signed [PROD_W-1:0]   w_ext, c_ext;
  logic signed [PROD_W-1:0]   prod;
  logic                       p_valid, p_first, p_last;
  logic signed [ACC_W-1:0]    acc, acc_next;
  logic                       a_done;
  logic signed [ACC_W-1:0]    rsum;
  logic signed [RND_W-1:0]    rq;
  logic signed [COORD_W-1:0]  sat;

  always_comb begin
    case (ctl.sel)
      TAP_0:   w_sel = w0;
      TAP_1:   w_sel = w1;
      default: w_sel = w2;
    endcase
    // unused tap of the linear blend contributes nothing
    c_use = ctl.use_pt ? coord : '0;
    w_ext = {{(PROD_W - WEIGHT_W){1'b0}}, w_sel};
    c_ext = {{(PROD_W - COORD_W){c_use[COORD_W-1]}}, c_use};
  end

  always_comb begin
    acc_next = {prod[PROD_W-1], prod};
    if (!p_first) begin
      acc_next = acc + {prod[PROD_W-1], prod};
    end
    // round half up, then clamp to the coordinate range
    rsum = acc + HALF;
    rq   = rsum[ACC_W-1:TOT_SHIFT];
    if (rq > MAX_R) begin
      sat = MAX_R[COORD_W-1:0];
    end else if (rq < MIN_R) begin
      sat = MIN_R[COORD_W-1:0];
    end else begin
      sat = rq[COORD_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid   <= 1'b0;
      a_done    <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      p_valid   <= ctl.valid;
      a_done    <= p_valid && p_last;
      res_valid <= a_done;
    end
    prod    <= w_ext * c_ext;
    p_first <= ctl.first;
    p_last  <= ctl.last;
    if (p_valid) begin
      acc <= acc_next;
    end
    if (a_done) begin
      res <= sat;
    end
  end

endmodule

// ===== design/quadratic_bspline_point_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quadratic_bspline_point_eval
// Clamped quadratic b-spline evaluator over a table of 2-D control points.
// ----------------------------------------------------------------------------
//  channel   signals                                          direction
//  request   start, busy, req_type, point_index, point_x,     in (busy out)
//            point_y, segment, fraction
//  result    done, curve_x, curve_y, status                   out
//  config    cfg_valid, cfg_ready, cfg_data (point_count)     in (ready out)
//
//  a write or an out-of-range evaluate gives its result in the next cycle and
//  a new beat may be taken at once. a valid evaluate spends a state on the
//  fraction squares, then three reads of the point ram (one port, one read a
//  cycle), then multiply, accumulate and round. reset sets point_count to 2;
//  the point table is undefined until written. results cannot be stalled.
// ----------------------------------------------------------------------------
module quadratic_bspline_point_eval (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  output logic                               busy,
  input  logic                               req_type,
  input  logic [qbs_pkg::IDX_W-1:0]          point_index,
  input  logic signed [qbs_pkg::COORD_W-1:0] point_x,
  input  logic signed [qbs_pkg::COORD_W-1:0] point_y,
  input  logic [qbs_pkg::IDX_W-1:0]          segment,
  input  logic [qbs_pkg::FRAC_W-1:0]         fraction,
  output logic                               done,
  output logic signed [qbs_pkg::COORD_W-1:0] curve_x,
  output logic signed [qbs_pkg::COORD_W-1:0] curve_y,
  output logic                               status,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [qbs_pkg::CNT_W-1:0]          cfg_data
);
  import qbs_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SQR,
    ST_READ,
    ST_WAIT
  } state_t;

  state_t                    state;
  logic [CNT_W-1:0]          point_count;
  logic [CNT_W-1:0]          pc_eff;
  logic [CNT_W-1:0]          seg_ext;
  logic                      accept, seg_bad, idx_ok, wr_en;
  mode_t                     mode_in, mode_q;
  logic [IDX_W-1:0]          seg_q;
  logic [FRAC_W-1:0]         frac_q;
  logic [1:0]                cnt;
  logic [IDX_W-1:0]          raddr;
  logic [2*COORD_W-1:0]      rdata;
  rd_ctl_t                   rd_ctl;
  weight_t                   w0, w1, w2;
  logic                      x_valid, y_valid;
  logic signed [COORD_W-1:0] x_res, y_res;

  assign cfg_ready = 1'b1;
  assign busy      = (state != ST_IDLE);
  assign accept    = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      point_count <= CNT_W'(2);
    end else if (cfg_valid && cfg_ready) begin
      point_count <= cfg_data;
    end
  end

  always_comb begin
    if (point_count < CNT_W'(2)) begin
      pc_eff = CNT_W'(2);
    end else if (point_count > CNT_W'(MAX_POINTS)) begin
      pc_eff = CNT_W'(MAX_POINTS);
    end else begin
      pc_eff = point_count;
    end
    seg_ext = {1'b0, segment};
    idx_ok  = {1'b0, point_index} < CNT_W'(MAX_POINTS);
    if (pc_eff == CNT_W'(2)) begin
      seg_bad = (segment != '0);
      mode_in = MODE_LINEAR;
    end else begin
      seg_bad = (seg_ext + CNT_W'(2)) >= pc_eff;
      if (segment == '0) begin
        mode_in = MODE_FIRST;
      end else if (seg_ext == pc_eff - CNT_W'(3)) begin
        mode_in = MODE_LAST;
      end else begin
        mode_in = MODE_UNIFORM;
      end
    end
  end

  // writes are taken only while idle, so they never meet a read in flight
  assign wr_en = accept && (req_type == REQ_WRITE) && idx_ok;
  assign raddr = seg_q + IDX_W'(cnt);

  qbs_ram #(
    .WIDTH (2 * COORD_W),
    .DEPTH (MAX_POINTS)
  ) u_ram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (point_index),
    .wdata ({point_y, point_x}),
    .raddr (raddr),
    .rdata (rdata)
  );

  qbs_weights u_weights (
    .clk  (clk),
    .frac (frac_q),
    .mode (mode_q),
    .w0   (w0),
    .w1   (w1),
    .w2   (w2)
  );

  qbs_mac u_mac_x (
    .clk       (clk),
    .rst       (rst),
    .ctl       (rd_ctl),
    .w0        (w0),
    .w1        (w1),
    .w2        (w2),
    .coord     (rdata[COORD_W-1:0]),
    .res_valid (x_valid),
    .res       (x_res)
  );

  qbs_mac u_mac_y (
    .clk       (clk),
    .rst       (rst),
    .ctl       (rd_ctl),
    .w0        (w0),
    .w1        (w1),
    .w2        (w2),
    .coord     (rdata[2*COORD_W-1:COORD_W]),
    .res_valid (y_valid),
    .res       (y_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      done         <= 1'b0;
      cnt          <= '0;
      rd_ctl.valid <= 1'b0;
    end else begin
      done         <= 1'b0;
      rd_ctl.valid <= 1'b0;
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            seg_q  <= segment;
            frac_q <= fraction;
            mode_q <= mode_in;
            cnt    <= '0;
            if (req_type == REQ_WRITE) begin
              done    <= 1'b1;
              curve_x <= '0;
              curve_y <= '0;
              status  <= !idx_ok;
            end else if (seg_bad) begin
              done    <= 1'b1;
              curve_x <= '0;
              curve_y <= '0;
              status  <= 1'b1;
            end else begin
              state <= ST_SQR;
            end
          end
        end
        ST_SQR: begin
          state <= ST_READ;
        end
        ST_READ: begin
          rd_ctl.valid  <= 1'b1;
          rd_ctl.sel    <= tap_t'(cnt);
          rd_ctl.first  <= (cnt == 2'd0);
          rd_ctl.last   <= (cnt == 2'd2);
          rd_ctl.use_pt <= !((mode_q == MODE_LINEAR) && (cnt == 2'd2));
          cnt           <= cnt + 2'd1;
          if (cnt == 2'd2) begin
            state <= ST_WAIT;
          end
        end
        ST_WAIT: begin
          if (x_valid && y_valid) begin
            done    <= 1'b1;
            curve_x <= x_res;
            curve_y <= y_res;
            status  <= 1'b0;
            state   <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule
